### design/spqr_pkg.sv
package spqr_pkg;

  // Default word format: signed fixed point, WORD_BITS wide, FRAC_BITS fraction bits
  localparam int SPQR_WORD_BITS = 32;
  localparam int SPQR_FRAC_BITS = 16;

endpackage

### design/spqr_sqrt_cell.sv
module spqr_sqrt_cell
  import spqr_pkg::*;
#(
  parameter int WORD_BITS = SPQR_WORD_BITS,
  parameter int TAG_W     = 2 + 2 * SPQR_WORD_BITS,
  parameter int K         = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [2*WORD_BITS+1:0] rem_i,
  input  logic [WORD_BITS:0]   root_i,
  input  logic [TAG_W-1:0]     tag_i,
  output logic [2*WORD_BITS+1:0] rem_o,
  output logic [WORD_BITS:0]   root_o,
  output logic [TAG_W-1:0]     tag_o
);

  localparam int DW = 2 * WORD_BITS + 2;
  localparam int RW = WORD_BITS + 1;

  logic [DW:0]   trial;
  logic          take;
  logic [DW-1:0] rem_nxt;
  logic [RW-1:0] root_nxt;

  // Try root bit K: (r + 2^K)^2 - r^2 = r * 2^(K+1) + 2^(2K)
  always_comb begin
    trial    = ({{(DW + 1 - RW){1'b0}}, root_i} << (K + 1)) | ((DW + 1)'(1) << (2 * K));
    take     = {1'b0, rem_i} >= trial;
    rem_nxt  = take ? rem_i - trial[DW-1:0] : rem_i;
    root_nxt = take ? (root_i | (RW'(1) << K)) : root_i;
  end

  // Hand the partial root to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= rem_nxt;
      root_o <= root_nxt;
      tag_o  <= tag_i;
    end
  end

endmodule

### design/spqr_div_cell.sv
module spqr_div_cell
  import spqr_pkg::*;
#(
  parameter int NW    = SPQR_WORD_BITS + 2 + SPQR_FRAC_BITS,
  parameter int DENW  = SPQR_WORD_BITS + 1,
  parameter int TAG_W = 2
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NW-1:0]    num_i,
  input  logic [NW-1:0]    quo_i,
  input  logic [DENW-1:0]  rem_i,
  input  logic [DENW-1:0]  den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic [NW-1:0]    num_o,
  output logic [NW-1:0]    quo_o,
  output logic [DENW-1:0]  rem_o,
  output logic [DENW-1:0]  den_o,
  output logic [TAG_W-1:0] tag_o
);

  logic [DENW:0]   rem2;
  logic [DENW:0]   diff;
  logic            take;

  // Bring down the next numerator bit and try one subtraction
  always_comb begin
    rem2 = {rem_i, num_i[NW-1]};
    diff = rem2 - {1'b0, den_i};
    take = rem2 >= {1'b0, den_i};
  end

  // Advance the partial quotient to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      num_o <= {num_i[NW-2:0], 1'b0};
      quo_o <= {quo_i[NW-2:0], take};
      rem_o <= take ? diff[DENW-1:0] : rem2[DENW-1:0];
      den_o <= den_i;
      tag_o <= tag_i;
    end
  end

endmodule

### design/smallest_positive_quadratic_root_top.sv
// Smallest non-negative root of a*t^2 + b*t + c, for ray-surface distance tests.
// Input channel (in_*): one transfer carries the coefficients a, b and c,
// signed fixed point with FRAC_BITS fraction bits in WORD_BITS-bit words.
// Output channel (out_*): one transfer per input transfer, in order, with the
// distance (unsigned fixed point) in tdata and the hit flag in tuser. A miss
// (no real distinct roots, a = 0, or both roots negative or out of range)
// gives an all-ones distance and hit = 0.
// Throughput: one transfer per cycle while the receiver does not stall. The
// pipeline holds a register for the products, one for the discriminant,
// one cell per root bit of the square root chain, a register for the
// numerators, one cell per numerator bit of the two divider chains, and the
// output register.
// When the receiver stalls with the output register full, the whole pipeline
// holds and in_tready drops until the output register is taken. Reset empties
// the pipeline; no transfers are in flight after it.
module smallest_positive_quadratic_root_top
  import spqr_pkg::*;
#(
  parameter int WORD_BITS = SPQR_WORD_BITS,
  parameter int FRAC_BITS = SPQR_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((3*WORD_BITS+7)/8)*8-1:0]     in_tdata,   // coef_a, coef_b, coef_c
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((WORD_BITS+7)/8)*8-1:0]       out_tdata,  // distance
  output logic                                 out_tuser   // hit
);

  localparam int W      = WORD_BITS;
  localparam int F      = FRAC_BITS;
  localparam int DW     = 2 * W + 2;
  localparam int RW     = W + 1;
  localparam int MW     = W + 2;
  localparam int NW     = MW + F;
  localparam int DENW   = W + 1;
  localparam int SQ_TW  = 2 + 2 * W;
  localparam int L      = RW + NW + 4;
  localparam int OUT_TW = ((W + 7) / 8) * 8;

  logic         adv;
  logic [L-1:0] vld_r;

  // Advance everything together whenever the output register is free
  assign adv       = !vld_r[L-1] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[L-2:0], in_tvalid};
    end
  end

  // Stage 1: magnitudes and products
  logic [W-1:0]   a_in, b_in, c_in;
  logic [W-1:0]   amag, bmag, cmag;
  logic [2*W-1:0] bb_r, ac_r;
  logic [W-1:0]   amag_r, b_r;
  logic           azero_r, aneg_r, addc_r;

  always_comb begin
    a_in = in_tdata[W-1:0];
    b_in = in_tdata[2*W-1:W];
    c_in = in_tdata[3*W-1:2*W];
    amag = a_in[W-1] ? ~a_in + 1'b1 : a_in;
    bmag = b_in[W-1] ? ~b_in + 1'b1 : b_in;
    cmag = c_in[W-1] ? ~c_in + 1'b1 : c_in;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bb_r    <= bmag * bmag;
      ac_r    <= amag * cmag;
      amag_r  <= amag;
      b_r     <= b_in;
      azero_r <= a_in == '0;
      aneg_r  <= a_in[W-1];
      addc_r  <= (c_in != '0) && (a_in[W-1] != c_in[W-1]);
    end
  end

  // Stage 2: discriminant and miss decision
  logic [DW-1:0] bbx, ac4, disc_r;
  logic          dok;
  logic [SQ_TW-1:0] sq_tag_r;

  always_comb begin
    bbx = {2'b00, bb_r};
    ac4 = {ac_r, 2'b00};
    dok = !azero_r && (addc_r || (bbx > ac4));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      disc_r   <= addc_r ? bbx + ac4 : bbx - ac4;
      sq_tag_r <= {dok, aneg_r, amag_r, b_r};
    end
  end

  // Square root chain, one root bit per cell
  logic [DW-1:0]    sq_rem  [0:RW];
  logic [RW-1:0]    sq_root [0:RW];
  logic [SQ_TW-1:0] sq_tag  [0:RW];

  assign sq_rem[0]  = disc_r;
  assign sq_root[0] = '0;
  assign sq_tag[0]  = sq_tag_r;

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    spqr_sqrt_cell #(
      .WORD_BITS (W),
      .TAG_W     (SQ_TW),
      .K         (RW - 1 - i)
    ) u_cell (
      .clk    (clk),
      .en     (adv),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .tag_i  (sq_tag[i]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .tag_o  (sq_tag[i+1])
    );
  end

  // Stage 3: both numerators, their signs and magnitudes
  logic           t_ok, t_aneg;
  logic [W-1:0]   t_amag, t_b;
  logic [W+2:0]   bx, sx, n1, n2, m1, m2;
  logic [NW-1:0]  num1_r, num2_r;
  logic [DENW-1:0] den_r;
  logic           ok_r, z1_r, s1_r, z2_r, s2_r;

  always_comb begin
    {t_ok, t_aneg, t_amag, t_b} = sq_tag[RW];
    bx = {{3{t_b[W-1]}}, t_b};
    sx = {2'b00, sq_root[RW]};
    n1 = -bx - sx;
    n2 = -bx + sx;
    m1 = n1[W+2] ? ~n1 + 1'b1 : n1;
    m2 = n2[W+2] ? ~n2 + 1'b1 : n2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num1_r <= {m1[MW-1:0], {F{1'b0}}};
      num2_r <= {m2[MW-1:0], {F{1'b0}}};
      den_r  <= {t_amag, 1'b0};
      ok_r   <= t_ok;
      z1_r   <= n1 == '0;
      s1_r   <= n1[W+2] == t_aneg;
      z2_r   <= n2 == '0;
      s2_r   <= n2[W+2] == t_aneg;
    end
  end

  // Divider chains, one quotient bit per cell
  logic [NW-1:0]   d1_num [0:NW], d2_num [0:NW];
  logic [NW-1:0]   d1_quo [0:NW], d2_quo [0:NW];
  logic [DENW-1:0] d1_rem [0:NW], d2_rem [0:NW];
  logic [DENW-1:0] d1_den [0:NW], d2_den [0:NW];
  logic [2:0]      d1_tag [0:NW];
  logic [1:0]      d2_tag [0:NW];

  assign d1_num[0] = num1_r;
  assign d1_quo[0] = '0;
  assign d1_rem[0] = '0;
  assign d1_den[0] = den_r;
  assign d1_tag[0] = {ok_r, z1_r, s1_r};
  assign d2_num[0] = num2_r;
  assign d2_quo[0] = '0;
  assign d2_rem[0] = '0;
  assign d2_den[0] = den_r;
  assign d2_tag[0] = {z2_r, s2_r};

  for (genvar j = 0; j < NW; j++) begin : g_div
    spqr_div_cell #(
      .NW    (NW),
      .DENW  (DENW),
      .TAG_W (3)
    ) u_cell1 (
      .clk   (clk),
      .en    (adv),
      .num_i (d1_num[j]),
      .quo_i (d1_quo[j]),
      .rem_i (d1_rem[j]),
      .den_i (d1_den[j]),
      .tag_i (d1_tag[j]),
      .num_o (d1_num[j+1]),
      .quo_o (d1_quo[j+1]),
      .rem_o (d1_rem[j+1]),
      .den_o (d1_den[j+1]),
      .tag_o (d1_tag[j+1])
    );

    spqr_div_cell #(
      .NW    (NW),
      .DENW  (DENW),
      .TAG_W (2)
    ) u_cell2 (
      .clk   (clk),
      .en    (adv),
      .num_i (d2_num[j]),
      .quo_i (d2_quo[j]),
      .rem_i (d2_rem[j]),
      .den_i (d2_den[j]),
      .tag_i (d2_tag[j]),
      .num_o (d2_num[j+1]),
      .quo_o (d2_quo[j+1]),
      .rem_o (d2_rem[j+1]),
      .den_o (d2_den[j+1]),
      .tag_o (d2_tag[j+1])
    );
  end

  // Final stage: range check, pick the smaller root, drive the output register
  logic          f_ok, f_z1, f_s1, f_z2, f_s2;
  logic          fit1, fit2, ok1, ok2;
  logic [W-1:0]  v1, v2, best;
  logic [W-1:0]  dist_r;
  logic          hit_r;

  always_comb begin
    {f_ok, f_z1, f_s1} = d1_tag[NW];
    {f_z2, f_s2}       = d2_tag[NW];
    fit1 = (d1_quo[NW][NW-1:W] == '0) && (d1_quo[NW][W-1:0] != '1);
    fit2 = (d2_quo[NW][NW-1:W] == '0) && (d2_quo[NW][W-1:0] != '1);
    ok1  = f_ok && (f_z1 || (f_s1 && fit1));
    ok2  = f_ok && (f_z2 || (f_s2 && fit2));
    v1   = f_z1 ? '0 : d1_quo[NW][W-1:0];
    v2   = f_z2 ? '0 : d2_quo[NW][W-1:0];
    if (ok1 && ok2) begin
      best = (v2 < v1) ? v2 : v1;
    end else if (ok1) begin
      best = v1;
    end else if (ok2) begin
      best = v2;
    end else begin
      best = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_r <= best;
      hit_r  <= ok1 || ok2;
    end
  end

  assign out_tvalid = vld_r[L-1];
  assign out_tdata  = OUT_TW'(dist_r);
  assign out_tuser  = hit_r;

endmodule

### verif/root_checker.sv
`timescale 1ns / 1ps

module root_checker
  import spqr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending
);

  localparam int WB = SPQR_WORD_BITS;
  localparam int FB = SPQR_FRAC_BITS;
  localparam logic [WB-1:0] SENTINEL = '1;

  typedef struct packed {
    logic [WB-1:0] distance;
    logic          hit;
  } hit_result_t;

  hit_result_t expected_hits[$];

  // floor of the square root of a non-negative wide value, bit by bit
  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  cand;
    r = '0;
    for (int k = 62; k >= 0; k--) begin
      cand = r | (64'd1 << k);
      if ({64'd0, cand} * {64'd0, cand} <= v) r = cand;
    end
    return r;
  endfunction

  // root num / 2a; ok is low for negative or out-of-range roots
  function automatic logic root_of(logic signed [65:0] num, logic signed [33:0] a,
                                   output logic [WB-1:0] val);
    logic [127:0] q;
    logic [127:0] n;
    logic [127:0] d;
    val = '0;
    if (num == 0) return 1'b1;
    if ((num < 0) != (a < 0)) return 1'b0;
    n = num < 0 ? -num : num;
    d = a < 0 ? -a : a;
    q = (n << FB) / (2 * d);
    if (q >= {96'd0, SENTINEL}) return 1'b0;
    val = q[WB-1:0];
    return 1'b1;
  endfunction

  function automatic hit_result_t nearest_root(logic [95:0] coefs);
    logic signed [WB-1:0]   a;
    logic signed [WB-1:0]   b;
    logic signed [WB-1:0]   c;
    logic signed [127:0]    disc;
    logic signed [65:0]     s;
    logic [WB-1:0]          v1;
    logic [WB-1:0]          v2;
    logic                   ok1;
    logic                   ok2;
    hit_result_t            r;
    a = coefs[WB-1:0];
    b = coefs[2*WB-1:WB];
    c = coefs[3*WB-1:2*WB];
    r.distance = SENTINEL;
    r.hit = 1'b0;
    if (a == 0) return r;
    disc = 128'(b) * 128'(b) - 128'sd4 * 128'(a) * 128'(c);
    if (disc <= 0) return r;
    s = 66'(isqrt(disc));
    ok1 = root_of(-66'(b) - s, 34'(a), v1);
    ok2 = root_of(-66'(b) + s, 34'(a), v2);
    if (ok1) r.distance = v1;
    if (ok2 && (!ok1 || v2 < r.distance)) r.distance = v2;
    r.hit = ok1 || ok2;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = expected_hits.size();

  // predict on each input transfer, compare on each output transfer
  always @(posedge clk) begin
    hit_result_t e;
    if (rst_n && in_tvalid && in_tready) expected_hits.push_back(nearest_root(in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected output transfer");
      end else begin
        e = expected_hits.pop_front();
        if (out_tdata !== e.distance)
          report_mismatch($sformatf("distance %h, want %h", out_tdata, e.distance));
        if (out_tuser !== e.hit)
          report_mismatch($sformatf("hit %b, want %b", out_tuser, e.hit));
      end
    end
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import spqr_pkg::*;

  localparam int ONE = 1 << SPQR_FRAC_BITS;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  int          fail_count;
  int          pending;

  smallest_positive_quadratic_root_top i_dut (.*);

  root_checker i_checker (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // random coefficient, biased toward small and edge values
  function automatic logic [31:0] draw_coef();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($signed($urandom_range(0, 16 * ONE)) - 8 * ONE);
      3: return 32'($signed($urandom_range(0, 512)) - 256);
      default: return 32'($signed($urandom_range(0, 256 * ONE)) - 128 * ONE);
    endcase
  endfunction

  // idle at random first, then hold the item until it is taken; valid stays high
  // after the transfer so that items can follow back to back
  task automatic send_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    int unsigned idle;
    idle = $urandom_range(0, 3);
    if (idle != 0) begin
      in_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {c, b, a};
    do @(posedge clk); while (!in_tready);
  endtask

  // receiver stalls at random before each transfer
  initial begin
    int unsigned idle;
    @(posedge rst_n);
    forever begin
      idle = $urandom_range(0, 3);
      if (idle != 0) begin
        out_tready <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    int signed r0;
    int signed r1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, a = 0, tangent, both negative, zero root, sphere
    send_coefs(0, 5 * ONE, -ONE);
    send_coefs(ONE, -2 * ONE, ONE);
    send_coefs(ONE, 3 * ONE, 2 * ONE);
    send_coefs(ONE, -3 * ONE, 2 * ONE);
    send_coefs(ONE, -ONE, 0);
    send_coefs(ONE, ONE, 0);
    send_coefs(ONE, 0, -4 * ONE);
    send_coefs(ONE, 0, ONE);
    send_coefs(-ONE, ONE, 2 * ONE);
    send_coefs(1, 0, -32'h7fffffff);
    send_coefs(1, 32'h80000000, 0);
    send_coefs(32'h80000000, 32'h7fffffff, 32'h7fffffff);
    send_coefs(32'h7fffffff, 32'h80000000, 32'h80000000);
    send_coefs(32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_coefs(32'h80000000, 32'h80000000, 32'h80000000);
    send_coefs(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_coefs(1, -1, 0);
    in_tvalid <= 1'b0;
    // hold until the pipeline drains
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < 1950; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        // well-formed roots, scaled by a
        r0 = $signed($urandom_range(0, 64 * ONE)) - 16 * ONE;
        r1 = $signed($urandom_range(0, 64 * ONE)) - 16 * ONE;
        send_coefs(ONE, -(r0 + r1), 32'((longint'(r0) * r1) >>> 16));
      end else begin
        send_coefs(draw_coef(), draw_coef(), draw_coef());
      end
    end
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
